// ===== design/edmc_pkg.sv =====
// ----------------------------------------------------------------------------
// edmc_pkg: shared types and constants for elevator dispatch
// Direction codes, mode codes, cost format and the record that travels
// from the costing front end to the selection back end.
// ----------------------------------------------------------------------------
`default_nettype none

package edmc_pkg;

   // building size, floors at or above this saturate to the top floor
   localparam int FLOOR_COUNT = 64;

   // default depth of the record queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // signed cost width, costs lie in -4..130
   localparam int COST_W = 9;

   // path penalties of the dispatch table
   localparam logic signed [COST_W-1:0] DETOUR_HI = 9'sd4;
   localparam logic signed [COST_W-1:0] DETOUR_LO = 9'sd2;

   // car mode codes that count as in service
   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_ACTIVE = 3'd1;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // one costed car record
   typedef struct packed {
      logic [3:0]               car_id;
      logic signed [COST_W-1:0] cost;
      logic                     in_service;
      logic                     last;
   } rec_type;

endpackage

`default_nettype wire

// ===== design/elevator_dispatch_min_cost.sv =====
// ----------------------------------------------------------------------------
// elevator_dispatch_min_cost: least-cost elevator selection for a hall call
// Output: the chosen id is registered as the final record leaves the queue.
// Throughput: one record per cycle; a final record waits on a pending result.
// Reset: synchronous; clears the queue, the run state and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_dispatch_min_cost
   import edmc_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [5:0] req_floor,
   input  wire logic [1:0] req_dir,
   input  wire logic [3:0] req_car_id,
   input  wire logic [5:0] req_car_floor,
   input  wire logic [1:0] req_car_dir,
   input  wire logic [2:0] req_car_mode,
   input  wire logic       req_queue_has,
   input  wire logic [5:0] req_queue_floor,
   input  wire logic [1:0] req_queue_dir,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_chosen_car
);

   rec_type front_rec, pop_rec;
   logic    pop_valid, pop_ready;

   // costing front end
   edmc_front u_front (
      .req_floor   (req_floor),
      .req_dir     (req_dir),
      .car_id      (req_car_id),
      .car_floor   (req_car_floor),
      .car_dir     (req_car_dir),
      .car_mode    (req_car_mode),
      .queue_has   (req_queue_has),
      .queue_floor (req_queue_floor),
      .queue_dir   (req_queue_dir),
      .last        (req_last),
      .rec         (front_rec)
   );

   // decoupling queue
   edmc_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_rec   (front_rec),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec)
   );

   // selection back end
   edmc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_rec        (pop_rec),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_chosen_car (rsp_chosen_car)
   );

   // a new result only follows the transfer of a final record
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pop_valid && pop_ready && pop_rec.last))
      else $error("result raised without a final record");

   // a final record never leaves the queue while a result is stuck
   assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready && pop_rec.last) |-> (!rsp_valid || rsp_ready))
      else $error("final record popped over a pending result");

   // queue is empty and open right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (req_ready && !pop_valid && !rsp_valid))
      else $error("queue or output not clear after reset");

endmodule

`default_nettype wire

// ===== design/edmc_front.sv =====
// ----------------------------------------------------------------------------
// edmc_front: car classification and dispatch cost
// Normalizes floors and directions of one status record and computes the
// cost of sending that car to the hall request.
// ----------------------------------------------------------------------------
`default_nettype none

module edmc_front
   import edmc_pkg::*;
(
   input  wire logic [5:0] req_floor,
   input  wire logic [1:0] req_dir,
   input  wire logic [3:0] car_id,
   input  wire logic [5:0] car_floor,
   input  wire logic [1:0] car_dir,
   input  wire logic [2:0] car_mode,
   input  wire logic       queue_has,
   input  wire logic [5:0] queue_floor,
   input  wire logic [1:0] queue_dir,
   input  wire logic       last,
   output rec_type         rec
);

   localparam logic [8:0] FLOOR_LIM = 9'(FLOOR_COUNT);
   localparam logic [5:0] FLOOR_TOP = 6'(FLOOR_COUNT - 1);

   function automatic logic [5:0] floor_sat(input logic [5:0] v);
      floor_sat = ({3'b000, v} >= FLOOR_LIM) ? FLOOR_TOP : v;
   endfunction

   function automatic dir_type dir_of(input logic [1:0] v);
      case (v)
         DIR_UP:   dir_of = DIR_UP;
         DIR_DOWN: dir_of = DIR_DOWN;
         default:  dir_of = DIR_NONE;
      endcase
   endfunction

   function automatic logic [5:0] gap(input logic [5:0] a, input logic [5:0] b);
      gap = (a > b) ? (a - b) : (b - a);
   endfunction

   logic [5:0]               tgt, cur, qf;
   dir_type                  rd, cd, qd;
   logic                     idle, ahead;
   logic [5:0]               dspan;
   logic [6:0]               path;
   logic signed [COST_W-1:0] d9, d9x2, p9, cost;

   // normalized fields
   assign tgt  = floor_sat(req_floor);
   assign cur  = floor_sat(car_floor);
   assign qf   = floor_sat(queue_floor);
   assign rd   = dir_of(req_dir);
   assign cd   = dir_of(car_dir);
   assign qd   = dir_of(queue_dir);
   assign idle = (car_mode == MODE_IDLE);

   // distances and heading test
   assign dspan = gap(cur, tgt);
   assign path  = {1'b0, gap(cur, qf)} + {1'b0, gap(qf, tgt)};
   assign ahead = ((cd == DIR_UP) && (tgt >= cur)) || ((cd == DIR_DOWN) && (tgt <= cur));
   assign d9    = signed'({3'b000, dspan});
   assign d9x2  = signed'({2'b00, dspan, 1'b0});
   assign p9    = signed'({2'b00, path});

   // dispatch cost table
   always_comb begin
      if ((cd == DIR_NONE) || idle) begin
         cost = d9;
      end else if (!queue_has) begin
         cost = ahead ? d9 : d9x2;
      end else if ((rd == DIR_NONE) || (qd == DIR_NONE)) begin
         cost = '0;
      end else if (rd == cd) begin
         if (qd == cd) begin
            cost = ahead ? (d9 - DETOUR_HI) : (p9 + DETOUR_LO);
         end else begin
            cost = p9 + DETOUR_HI;
         end
      end else if (qd == rd) begin
         cost = ahead ? (p9 - DETOUR_LO) : (p9 + DETOUR_HI);
      end else begin
         cost = p9 + DETOUR_HI;
      end
   end

   // record for the selection stage
   assign rec.car_id     = car_id;
   assign rec.cost       = cost;
   assign rec.in_service = (car_mode == MODE_IDLE) || (car_mode == MODE_ACTIVE);
   assign rec.last       = last;

endmodule

`default_nettype wire

// ===== design/edmc_queue.sv =====
// ----------------------------------------------------------------------------
// edmc_queue: small register queue between costing and selection
// Circular buffer of costed records; lets the front and back stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module edmc_queue
   import edmc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic      push_ready,
   input  rec_type   push_rec,
   output logic      pop_valid,
   input  wire logic pop_ready,
   output rec_type   pop_rec
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   rec_type       slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_rec    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

// ===== design/edmc_back.sv =====
// ----------------------------------------------------------------------------
// edmc_back: running least-cost selection
// Keeps the strict minimum over in-service cars of a run (else the run's first car)
// and issues the chosen car id through an output register on the run's final record.
// ----------------------------------------------------------------------------
`default_nettype none

module edmc_back
   import edmc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  pop_valid,
   output logic       pop_ready,
   input  rec_type    pop_rec,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output logic [3:0] rsp_chosen_car
);

   logic                     seen_first_ff, seen_first_in;
   logic                     have_best_ff, have_best_in;
   logic [3:0]               best_car_ff, best_car_in;
   logic signed [COST_W-1:0] best_cost_ff, best_cost_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [3:0]               rsp_car_ff, rsp_car_in;
   logic                     take, do_pop;
   logic [3:0]               base_car;

   // a final record needs a free output slot
   assign pop_ready = !pop_rec.last || !rsp_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;

   // strict compare keeps the earlier car on ties
   assign base_car = seen_first_ff ? best_car_ff : pop_rec.car_id;
   assign take     = pop_rec.in_service && (!have_best_ff || (pop_rec.cost < best_cost_ff));

   always_comb begin
      seen_first_in = seen_first_ff;
      have_best_in  = have_best_ff;
      best_car_in   = best_car_ff;
      best_cost_in  = best_cost_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_car_in    = rsp_car_ff;
      if (do_pop) begin
         if (pop_rec.last) begin
            rsp_valid_in  = 1'b1;
            rsp_car_in    = take ? pop_rec.car_id : base_car;
            seen_first_in = 1'b0;
            have_best_in  = 1'b0;
         end else begin
            seen_first_in = 1'b1;
            have_best_in  = have_best_ff || take;
            best_car_in   = take ? pop_rec.car_id : base_car;
            best_cost_in  = take ? pop_rec.cost : best_cost_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_first_ff <= 1'b0;
         have_best_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seen_first_ff <= seen_first_in;
         have_best_ff  <= have_best_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      best_car_ff  <= best_car_in;
      best_cost_ff <= best_cost_in;
      rsp_car_ff   <= rsp_car_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_chosen_car = rsp_car_ff;

endmodule

`default_nettype wire
